### src/mps_pkg.sv
// Shared types, codes and constants of the monochrome pixel store.
`timescale 1ns / 1ps
package mps_pkg;

  // Default store depth in bytes
  localparam int STORE_BYTES_DEF = 1024;

  // Width of a computed byte address (largest is 8160 in linear layout)
  localparam int CALC_W  = 13;
  // Width used to compare against the store depth (up to 65536)
  localparam int LIMIT_W = 17;

  // Field and register widths
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 8;
  localparam int LAYOUT_W = 2;
  localparam int WIDTH_W  = 8;
  localparam int BYTES_W  = 11;
  localparam int CFG_IDX_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLR   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_WIPE  = 2'd3;

  // Layout codes; the unused code addresses like linear
  localparam logic [LAYOUT_W-1:0] LAYOUT_LINEAR   = 2'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_VERTICAL = 2'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_PICTURE  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES  = 2'd2;

  // Picture layout row stride in bytes
  localparam logic [3:0] PICT_STRIDE = 4'd9;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_MOD,
    ST_WIPE,
    ST_RESP
  } state_t;

  // Located pixel: byte address, bit mask, out-of-store flag
  typedef struct packed {
    logic [CALC_W-1:0] addr;
    logic [7:0]        mask;
    logic              err;
  } loc_t;

endpackage

### src/monochrome_pixel_store_unit.sv
// Top level of the monochrome pixel store: control, configuration and result registers.
// Pixel operations: address registered, byte read, modified byte written back, then the
// result strobed; busy holds off a new start until the write back, so items never overlap.
// Clear-image: min(image_bytes, STORE_BYTES) bytes cleared, one byte written per cycle.
// Reset: a clearing pass zeroes every byte of the store with busy high;
// configuration writes are taken throughout. The receiver cannot stall results.
`timescale 1ns / 1ps
module monochrome_pixel_store_unit #(
  parameter int STORE_BYTES = mps_pkg::STORE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mps_pkg::FUNC_W-1:0]    in_func,
  input  logic [mps_pkg::POS_W-1:0]     in_pos_x,
  input  logic [mps_pkg::POS_W-1:0]     in_pos_y,
  output logic                          out_strobe,
  output logic                          out_pixel,
  output logic                          out_addr_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mps_pkg::BYTES_W-1:0]   cfg_data
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  mps_pkg::state_t state_r, state_nxt;

  logic [mps_pkg::LAYOUT_W-1:0] layout_r;
  logic [mps_pkg::WIDTH_W-1:0]  width_r;
  logic [mps_pkg::BYTES_W-1:0]  bytes_r;

  mps_pkg::loc_t               loc;
  mps_pkg::loc_t               loc_r, loc_nxt;
  logic [mps_pkg::FUNC_W-1:0]  func_r, func_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [AW-1:0]               last_r, last_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_pixel_r, out_pixel_nxt;
  logic                        out_err_r, out_err_nxt;

  logic [mps_pkg::LIMIT_W-1:0] bytes_ext;
  logic [AW-1:0]               wipe_last;
  logic                        accept;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [7:0]                  mem_wdata;
  logic [7:0]                  mem_rdata;
  logic                        old_bit;

  // Address computation
  mps_locate #(
    .STORE_BYTES(STORE_BYTES)
  ) u_locate (
    .layout      (layout_r),
    .image_width (width_r),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .loc         (loc)
  );

  // Image memory
  mps_store #(
    .AW(AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (AW'(loc_r.addr)),
    .rdata (mem_rdata)
  );

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= '0;
      width_r  <= '0;
      bytes_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mps_pkg::REG_LAYOUT: layout_r <= cfg_data[mps_pkg::LAYOUT_W-1:0];
        mps_pkg::REG_WIDTH:  width_r  <= cfg_data[mps_pkg::WIDTH_W-1:0];
        mps_pkg::REG_BYTES:  bytes_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Last byte of a clear-image walk, capped at the store size
  assign bytes_ext = mps_pkg::LIMIT_W'(bytes_r);
  assign wipe_last = (bytes_ext >= mps_pkg::LIMIT_W'(STORE_BYTES)) ? LAST_ADDR
                   : AW'(bytes_ext - mps_pkg::LIMIT_W'(1));

  assign busy    = (state_r != mps_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign old_bit = |(mem_rdata & loc_r.mask);

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    loc_nxt       = loc_r;
    func_nxt      = func_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_pixel_nxt = 1'b0;
    out_err_nxt   = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = 8'h00;
    case (state_r)
      mps_pkg::ST_INIT: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == LAST_ADDR) begin
          idx_nxt   = '0;
          state_nxt = mps_pkg::ST_IDLE;
        end
      end
      mps_pkg::ST_IDLE: begin
        if (accept) begin
          loc_nxt  = loc;
          func_nxt = in_func;
          idx_nxt  = '0;
          last_nxt = wipe_last;
          if (in_func == mps_pkg::FUNC_WIPE) begin
            state_nxt = (bytes_r == '0) ? mps_pkg::ST_RESP : mps_pkg::ST_WIPE;
          end else begin
            state_nxt = mps_pkg::ST_RD;
          end
        end
      end
      mps_pkg::ST_RD: begin
        state_nxt = mps_pkg::ST_MOD;
      end
      mps_pkg::ST_MOD: begin
        // Read-modify-write of the addressed byte
        mem_waddr = AW'(loc_r.addr);
        if (func_r == mps_pkg::FUNC_SET) begin
          mem_wdata = mem_rdata | loc_r.mask;
        end else begin
          mem_wdata = mem_rdata & ~loc_r.mask;
        end
        mem_we = !loc_r.err &&
                 (func_r == mps_pkg::FUNC_SET || func_r == mps_pkg::FUNC_CLR);
        out_valid_nxt = 1'b1;
        out_pixel_nxt = !loc_r.err && old_bit;
        out_err_nxt   = loc_r.err;
        state_nxt     = mps_pkg::ST_IDLE;
      end
      mps_pkg::ST_WIPE: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == last_r) begin
          idx_nxt   = '0;
          state_nxt = mps_pkg::ST_RESP;
        end
      end
      mps_pkg::ST_RESP: begin
        out_valid_nxt = 1'b1;
        state_nxt     = mps_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mps_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mps_pkg::ST_INIT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    loc_r       <= loc_nxt;
    func_r      <= func_nxt;
    last_r      <= last_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_strobe     = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_addr_error = out_err_r;

  // Every accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after a transfer was taken");

  // A result always follows a final state of an item
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == mps_pkg::ST_MOD || $past(state_r) == mps_pkg::ST_RESP))
    else $error("result strobe without a finished item");

  // An out-of-store access never reports a lit pixel
  a_err_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_addr_error |-> !out_pixel)
    else $error("pixel lit on an address error");

  // Out-of-store accesses never write the memory
  a_err_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mps_pkg::ST_MOD && loc_r.err |-> !mem_we)
    else $error("memory written on an address error");

  // The clear walk stays within its bound
  a_wipe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mps_pkg::ST_WIPE |-> idx_r <= last_r)
    else $error("clear walk past its last byte");

endmodule

### src/mps_locate.sv
// Pixel locator: byte address and bit mask of a pixel under the current layout.
`timescale 1ns / 1ps
module mps_locate #(
  parameter int STORE_BYTES = mps_pkg::STORE_BYTES_DEF
) (
  input  logic [mps_pkg::LAYOUT_W-1:0] layout,
  input  logic [mps_pkg::WIDTH_W-1:0]  image_width,
  input  logic [mps_pkg::POS_W-1:0]    pos_x,
  input  logic [mps_pkg::POS_W-1:0]    pos_y,
  output mps_pkg::loc_t                loc
);

  logic [7:0]                   mul_a;
  logic [15:0]                  prod;
  logic [15:0]                  lin_n;
  logic [mps_pkg::CALC_W-1:0]   vert_addr;
  logic [mps_pkg::CALC_W-1:0]   pict_addr;

  // One shared 8x8 multiplier: row index for linear, band index for vertical
  assign mul_a = (layout == mps_pkg::LAYOUT_VERTICAL) ? {3'b000, pos_y[7:3]} : pos_y;
  assign prod  = mul_a * image_width;

  assign lin_n     = prod + 16'(pos_x);
  assign vert_addr = mps_pkg::CALC_W'(prod) + mps_pkg::CALC_W'(pos_x);
  assign pict_addr = mps_pkg::CALC_W'(pos_y) * mps_pkg::CALC_W'(mps_pkg::PICT_STRIDE)
                   + mps_pkg::CALC_W'(pos_x[7:3]);

  // Layout select
  always_comb begin
    case (layout)
      mps_pkg::LAYOUT_VERTICAL: begin
        loc.addr = vert_addr;
        loc.mask = 8'h01 << pos_y[2:0];
      end
      mps_pkg::LAYOUT_PICTURE: begin
        loc.addr = pict_addr;
        loc.mask = 8'h80 >> pos_x[2:0];
      end
      default: begin
        loc.addr = lin_n[15:3];
        loc.mask = 8'h80 >> lin_n[2:0];
      end
    endcase
    loc.err = {{(mps_pkg::LIMIT_W-mps_pkg::CALC_W){1'b0}}, loc.addr}
              >= mps_pkg::LIMIT_W'(STORE_BYTES);
  end

endmodule

### src/mps_store.sv
// Byte-wide image memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module mps_store #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];
  logic [7:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Synchronous read with registered data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### tb/sv/monochrome_pixel_store_checker.sv
// Checker for the monochrome pixel store: tracks registers, predicts results, compares them.
`timescale 1ns / 1ps
module monochrome_pixel_store_checker #(
  parameter int STORE_BYTES = mps_pkg::STORE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [mps_pkg::FUNC_W-1:0]    in_func,
  input  logic [mps_pkg::POS_W-1:0]     in_pos_x,
  input  logic [mps_pkg::POS_W-1:0]     in_pos_y,
  input  logic                          out_strobe,
  input  logic                          out_pixel,
  input  logic                          out_addr_error,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mps_pkg::BYTES_W-1:0]   cfg_data,
  output int                            fail_count,
  output int                            open_items
);

  typedef struct packed {
    logic pixel;
    logic addr_error;
  } pixel_result_t;

  typedef struct packed {
    logic [31:0] byte_addr;
    logic [7:0]  bit_mask;
  } pixel_loc_t;

  // Shadow of the store and of the registers
  logic [7:0]                   image_copy [STORE_BYTES];
  logic [mps_pkg::LAYOUT_W-1:0] layout_q;
  logic [mps_pkg::WIDTH_W-1:0]  width_q;
  logic [mps_pkg::BYTES_W-1:0]  bytes_q;

  pixel_result_t pixel_results_q [$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Byte and bit of a pixel under the current layout; spare layout code acts as linear
  function automatic pixel_loc_t locate_pixel(input logic [7:0] x, input logic [7:0] y);
    pixel_loc_t  loc;
    int unsigned xi;
    int unsigned yi;
    int unsigned wi;
    int unsigned n;
    xi = 32'(x);
    yi = 32'(y);
    wi = 32'(width_q);
    case (layout_q)
      mps_pkg::LAYOUT_VERTICAL: begin
        loc.byte_addr = (yi / 8) * wi + xi;
        loc.bit_mask  = 8'h01 << (yi % 8);
      end
      mps_pkg::LAYOUT_PICTURE: begin
        loc.byte_addr = mps_pkg::PICT_STRIDE * yi + xi / 8;
        loc.bit_mask  = 8'h80 >> (xi % 8);
      end
      default: begin
        n             = yi * wi + xi;
        loc.byte_addr = n / 8;
        loc.bit_mask  = 8'h80 >> (n % 8);
      end
    endcase
    return loc;
  endfunction

  // Applies one operation to the shadow store and returns its result
  function automatic pixel_result_t predict_pixel_op(input logic [mps_pkg::FUNC_W-1:0] f,
                                                     input logic [7:0] x,
                                                     input logic [7:0] y);
    pixel_result_t res;
    pixel_loc_t    loc;
    int unsigned   wipe_len;
    logic [7:0]    old_byte;
    res = '0;
    if (f == mps_pkg::FUNC_WIPE) begin
      wipe_len = (bytes_q > STORE_BYTES) ? STORE_BYTES : bytes_q;
      for (int i = 0; i < wipe_len; i++) image_copy[i] = 8'h00;
      return res;
    end
    loc = locate_pixel(x, y);
    if (loc.byte_addr >= STORE_BYTES) begin
      res.addr_error = 1'b1;
      return res;
    end
    old_byte = image_copy[loc.byte_addr];
    if (f == mps_pkg::FUNC_SET) image_copy[loc.byte_addr] = old_byte | loc.bit_mask;
    else if (f == mps_pkg::FUNC_CLR) image_copy[loc.byte_addr] = old_byte & ~loc.bit_mask;
    res.pixel = |(old_byte & loc.bit_mask);
    return res;
  endfunction

  // Watch all three channels on each rising edge
  always @(posedge clk) begin : watch
    pixel_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < STORE_BYTES; i++) image_copy[i] = 8'h00;
      layout_q = '0;
      width_q  = '0;
      bytes_q  = '0;
      pixel_results_q.delete();
    end else begin
      // result first, so a transfer in the same cycle cannot match itself
      if (out_strobe) begin
        if (pixel_results_q.size() == 0) begin
          report_mismatch("result strobe with no result expected");
        end else begin
          exp_r = pixel_results_q.pop_front();
          if (out_pixel !== exp_r.pixel)
            report_mismatch($sformatf("pixel %b, expected %b", out_pixel, exp_r.pixel));
          if (out_addr_error !== exp_r.addr_error)
            report_mismatch($sformatf("addr_error %b, expected %b",
                                      out_addr_error, exp_r.addr_error));
        end
      end
      if (start && !busy)
        pixel_results_q.push_back(predict_pixel_op(in_func, in_pos_x, in_pos_y));
      // register writes; an index past the list is dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mps_pkg::REG_LAYOUT: layout_q = cfg_data[mps_pkg::LAYOUT_W-1:0];
          mps_pkg::REG_WIDTH:  width_q  = cfg_data[mps_pkg::WIDTH_W-1:0];
          mps_pkg::REG_BYTES:  bytes_q  = cfg_data;
          default: ;
        endcase
      end
    end
    open_items = pixel_results_q.size();
  end

endmodule

### tb/sv/monochrome_pixel_store_unit_tb.sv
// Testbench top for the monochrome pixel store: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module monochrome_pixel_store_unit_tb;

  localparam int STORE_BYTES = mps_pkg::STORE_BYTES_DEF;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int PHASE_ITEMS = 215;
  localparam int RECENT_MAX  = 16;

  // Codes outside the documented lists, used to check they are handled
  localparam logic [mps_pkg::CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
  localparam logic [mps_pkg::LAYOUT_W-1:0]  LAYOUT_SPARE = 2'd3;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          start          = 1'b0;
  logic                          busy;
  logic [mps_pkg::FUNC_W-1:0]    in_func        = '0;
  logic [mps_pkg::POS_W-1:0]     in_pos_x       = '0;
  logic [mps_pkg::POS_W-1:0]     in_pos_y       = '0;
  logic                          out_strobe;
  logic                          out_pixel;
  logic                          out_addr_error;
  logic                          cfg_valid      = 1'b0;
  logic                          cfg_ready;
  logic [mps_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
  logic [mps_pkg::BYTES_W-1:0]   cfg_data       = '0;

  int fail_count;
  int open_items;
  int cycle_count = 0;

  // Register values as last written, used only to aim coordinates into the store
  logic [mps_pkg::LAYOUT_W-1:0] cur_layout = '0;
  logic [mps_pkg::WIDTH_W-1:0]  cur_width  = '0;

  logic [15:0] recent_px [$];

  always #4 clk = ~clk;

  monochrome_pixel_store_unit #(.STORE_BYTES(STORE_BYTES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .out_strobe(out_strobe), .out_pixel(out_pixel), .out_addr_error(out_addr_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  monochrome_pixel_store_checker #(.STORE_BYTES(STORE_BYTES)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .out_strobe(out_strobe), .out_pixel(out_pixel), .out_addr_error(out_addr_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .open_items(open_items)
  );

  // One register transfer; valid drops again once the transfer is taken
  task automatic write_reg(input logic [mps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mps_pkg::BYTES_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      mps_pkg::REG_LAYOUT: cur_layout = data[mps_pkg::LAYOUT_W-1:0];
      mps_pkg::REG_WIDTH:  cur_width  = data[mps_pkg::WIDTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [mps_pkg::LAYOUT_W-1:0] lay,
                               input logic [mps_pkg::BYTES_W-1:0] w,
                               input logic [mps_pkg::BYTES_W-1:0] nbytes);
    write_reg(mps_pkg::REG_LAYOUT, mps_pkg::BYTES_W'(lay));
    write_reg(mps_pkg::REG_WIDTH, w);
    write_reg(mps_pkg::REG_BYTES, nbytes);
  endtask

  // Start stays high across back-to-back items; returns at the accepting edge
  task automatic issue_op(input logic [mps_pkg::FUNC_W-1:0] f, input logic [7:0] x,
                          input logic [7:0] y);
    @(negedge clk);
    start    <= 1'b1;
    in_func  <= f;
    in_pos_x <= x;
    in_pos_y <= y;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start and wait until every result of the phase is back
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (open_items != 0) @(negedge clk);
  endtask

  // Highest row that still tends to land inside the store
  function automatic int row_limit();
    int lim;
    case (cur_layout)
      mps_pkg::LAYOUT_VERTICAL:
        lim = (cur_width == 0) ? 255 : (STORE_BYTES / cur_width) * 8 + 7;
      mps_pkg::LAYOUT_PICTURE:  lim = STORE_BYTES / mps_pkg::PICT_STRIDE;
      default:         lim = (cur_width == 0) ? 255 : (STORE_BYTES * 8) / cur_width;
    endcase
    return (lim > 255) ? 255 : lim;
  endfunction

  // Mostly in-store pixels, often revisited, with some wild coordinates and wipes
  task automatic random_op(input int idle_pct);
    logic [mps_pkg::FUNC_W-1:0] f;
    logic [7:0]                 x;
    logic [7:0]                 y;
    logic [15:0]                xy;
    int                         pick;
    if ($urandom_range(1, 100) <= idle_pct) hold_off($urandom_range(1, 4));
    pick = $urandom_range(1, 100);
    x = 8'($urandom);
    y = 8'($urandom);
    if (pick <= 4) begin
      f = mps_pkg::FUNC_WIPE;
    end else begin
      f = mps_pkg::FUNC_W'($urandom_range(mps_pkg::FUNC_READ, mps_pkg::FUNC_CLR));
      if (pick <= 34 && recent_px.size() > 0) begin
        xy = recent_px[$urandom_range(0, recent_px.size() - 1)];
        x  = xy[15:8];
        y  = xy[7:0];
      end else if (pick <= 84) begin
        y = 8'($urandom_range(0, row_limit()));
      end
      recent_px.push_back({x, y});
      if (recent_px.size() > RECENT_MAX) void'(recent_px.pop_front());
    end
    issue_op(f, x, y);
  endtask

  task automatic run_phase(input logic [mps_pkg::LAYOUT_W-1:0] lay,
                           input logic [mps_pkg::BYTES_W-1:0] w,
                           input logic [mps_pkg::BYTES_W-1:0] nbytes, input int idle_pct);
    apply_setting(lay, w, nbytes);
    recent_px.delete();
    repeat (PHASE_ITEMS) random_op(idle_pct);
    drain();
  endtask

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Linear, widest rows; high data bits must be masked, spare index ignored
    write_reg(mps_pkg::REG_LAYOUT, 11'h7FC);
    write_reg(mps_pkg::REG_WIDTH, 11'h7FF);
    write_reg(mps_pkg::REG_BYTES, 11'd1024);
    write_reg(REG_UNUSED, 11'h7FF);
    issue_op(mps_pkg::FUNC_READ, 8'd0, 8'd0);
    issue_op(mps_pkg::FUNC_SET, 8'd0, 8'd0);
    issue_op(mps_pkg::FUNC_READ, 8'd0, 8'd0);
    issue_op(mps_pkg::FUNC_SET, 8'd7, 8'd0);
    issue_op(mps_pkg::FUNC_SET, 8'd255, 8'd31);      // near the end of the store
    issue_op(mps_pkg::FUNC_READ, 8'd255, 8'd255);    // beyond the store
    issue_op(mps_pkg::FUNC_CLR, 8'd255, 8'd255);
    issue_op(mps_pkg::FUNC_CLR, 8'd0, 8'd0);
    issue_op(mps_pkg::FUNC_WIPE, 8'd255, 8'd255);
    issue_op(mps_pkg::FUNC_READ, 8'd255, 8'd31);
    drain();

    // Vertical bytes, zero width, zero-length wipe
    apply_setting(mps_pkg::LAYOUT_VERTICAL, 11'd0, 11'd0);
    issue_op(mps_pkg::FUNC_SET, 8'd255, 8'd255);
    issue_op(mps_pkg::FUNC_READ, 8'd255, 8'd7);
    issue_op(mps_pkg::FUNC_WIPE, 8'd0, 8'd0);
    issue_op(mps_pkg::FUNC_READ, 8'd255, 8'd255);
    issue_op(mps_pkg::FUNC_SET, 8'd0, 8'd0);
    drain();

    // Picture rows, wipe length above the store size
    apply_setting(mps_pkg::LAYOUT_PICTURE, 11'd128, 11'h7FF);
    issue_op(mps_pkg::FUNC_SET, 8'd255, 8'd113);
    issue_op(mps_pkg::FUNC_READ, 8'd255, 8'd111);
    issue_op(mps_pkg::FUNC_SET, 8'd255, 8'd110);
    issue_op(mps_pkg::FUNC_READ, 8'd0, 8'd0);
    issue_op(mps_pkg::FUNC_WIPE, 8'd0, 8'd0);
    issue_op(mps_pkg::FUNC_READ, 8'd255, 8'd110);
    drain();

    // Spare layout code addresses as linear
    apply_setting(LAYOUT_SPARE, 11'd1, 11'd17);
    issue_op(mps_pkg::FUNC_SET, 8'd255, 8'd255);
    issue_op(mps_pkg::FUNC_READ, 8'd255, 8'd255);
    issue_op(mps_pkg::FUNC_CLR, 8'd255, 8'd255);
    drain();

    // Random phases over several settings and sender idle rates
    run_phase(mps_pkg::LAYOUT_LINEAR, 11'd255, 11'd1024, 0);
    run_phase(mps_pkg::LAYOUT_VERTICAL, 11'd0, 11'd0, 51);
    run_phase(mps_pkg::LAYOUT_PICTURE, 11'd128, 11'h7FF, 24);
    run_phase(LAYOUT_SPARE, 11'd1, 11'd17, 0);
    run_phase(mps_pkg::LAYOUT_VERTICAL, 11'd255, 11'd1, 51);
    run_phase(mps_pkg::LAYOUT_LINEAR, 11'd37, 11'd300, 24);
    run_phase(mps_pkg::LAYOUT_PICTURE, 11'd0, 11'd1023, 51);

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
